>>> rtl/stlv_pkg.sv
// ----------------------------------------------------------------------------
// stlv_pkg
// shared widths, header sizes and the result record of the tlv byte deframer
// ----------------------------------------------------------------------------
package stlv_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned SYNC_W       = 16;
	localparam int unsigned TYPE_BYTES   = 4;
	localparam int unsigned LENGTH_BYTES = 4;

	typedef struct packed {
		logic              value_valid;
		logic [BYTE_W-1:0] out_value;
		logic [WORD_W-1:0] value_offset;
		logic              packet_done;
		logic [WORD_W-1:0] packet_type;
		logic [WORD_W-1:0] packet_length;
	} stlv_result_t;

endpackage

>>> rtl/stlv_ifs.sv
// ----------------------------------------------------------------------------
// stlv channel interfaces
// valid/ready channels for stream bytes and for deframed result records
// ----------------------------------------------------------------------------
interface stlv_byte_if;
	logic                          valid;
	logic                          ready;
	logic [stlv_pkg::BYTE_W-1:0]   in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface stlv_result_if;
	logic                   valid;
	logic                   ready;
	stlv_pkg::stlv_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sync_tlv_byte_deframer.sv
// ----------------------------------------------------------------------------
// sync_tlv_byte_deframer
// hunts a 16-bit sync word, then collects a big-endian type and length and
// passes on each value byte with its offset, flagging the end of the packet
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  stream    | in  | valid / ready      | in_byte
//  result    | out | valid / ready      | data (stlv_result_t)
//  cfg       | in  | cfg_we             | cfg_wdata (sync word)
//
// one byte per cycle sustained; a byte waits in the input register and its
// record, if any, enters the result register as the byte leaves it. a held
// result stalls the input register only when that byte makes a record: the
// value bytes and an empty packet's last length byte; other bytes never wait.
// arst_n clears the phase, window, fields, count and the sync word to zero.
// ----------------------------------------------------------------------------
module sync_tlv_byte_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [stlv_pkg::SYNC_W-1:0]   cfg_wdata,
	stlv_byte_if.sink                     stream,
	stlv_result_if.source                 result
);

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_TYPE   = 2'd1;
	localparam logic [1:0] PH_LENGTH = 2'd2;
	localparam logic [1:0] PH_VALUE  = 2'd3;

	localparam logic [stlv_pkg::WORD_W-1:0] TYPE_LAST =
		stlv_pkg::WORD_W'(stlv_pkg::TYPE_BYTES - 1);
	localparam logic [stlv_pkg::WORD_W-1:0] LENGTH_LAST =
		stlv_pkg::WORD_W'(stlv_pkg::LENGTH_BYTES - 1);

	logic [stlv_pkg::SYNC_W-1:0] sync_q;
	logic [1:0]                  phase_q, phase_d;
	logic [stlv_pkg::SYNC_W-1:0] win_q, win_d;
	logic [stlv_pkg::WORD_W-1:0] type_q, type_d;
	logic [stlv_pkg::WORD_W-1:0] len_q, len_d;
	logic [stlv_pkg::WORD_W-1:0] cnt_q, cnt_d;
	logic [stlv_pkg::WORD_W-1:0] cnt_inc;

	logic                        valid_s1;
	logic [stlv_pkg::BYTE_W-1:0] byte_s1;
	logic                        emit;
	logic                        adv_s1;
	stlv_pkg::stlv_result_t      res_d;
	logic                        res_valid_q;
	stlv_pkg::stlv_result_t      res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= '0;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// input register
	assign adv_s1       = valid_s1 && (!emit || !res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.in_byte;
		end
	end

	// deframing step
	assign cnt_inc = cnt_q + stlv_pkg::WORD_W'(1);

	always_comb begin
		phase_d = phase_q;
		win_d   = win_q;
		type_d  = type_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		emit    = 1'b0;
		res_d   = '0;
		res_d.packet_type   = type_q;
		res_d.packet_length = len_q;
		case (phase_q)
			PH_HUNT: begin
				win_d = {win_q[stlv_pkg::SYNC_W-stlv_pkg::BYTE_W-1:0], byte_s1};
				if (win_d == sync_q) begin
					phase_d = PH_TYPE;
					cnt_d   = '0;
					type_d  = '0;
					len_d   = '0;
				end
			end
			PH_TYPE: begin
				type_d = {type_q[stlv_pkg::WORD_W-stlv_pkg::BYTE_W-1:0], byte_s1};
				cnt_d  = cnt_inc;
				if (cnt_q == TYPE_LAST) begin
					phase_d = PH_LENGTH;
					cnt_d   = '0;
				end
			end
			PH_LENGTH: begin
				len_d = {len_q[stlv_pkg::WORD_W-stlv_pkg::BYTE_W-1:0], byte_s1};
				cnt_d = cnt_inc;
				if (cnt_q == LENGTH_LAST) begin
					cnt_d = '0;
					if (len_d != '0) begin
						phase_d = PH_VALUE;
					end else begin
						// empty payload closes the packet here
						phase_d             = PH_HUNT;
						emit                = 1'b1;
						res_d.packet_done   = 1'b1;
						res_d.packet_length = len_d;
					end
				end
			end
			PH_VALUE: begin
				cnt_d              = cnt_inc;
				emit               = 1'b1;
				res_d.value_valid  = 1'b1;
				res_d.out_value    = byte_s1;
				res_d.value_offset = cnt_q;
				res_d.packet_done  = (cnt_inc == len_q);
				if (cnt_inc == len_q) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			win_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (adv_s1) begin
			phase_q <= phase_d;
			win_q   <= win_d;
			type_q  <= type_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// checks
	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.value_valid |->
			result.data.packet_done && result.data.packet_length == '0)
		else $error("record without value byte is not an empty packet end");

	a_last_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.value_valid && result.data.packet_done |->
			result.data.value_offset + stlv_pkg::WORD_W'(1) == result.data.packet_length)
		else $error("packet end flagged away from the last value byte");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit |=> res_valid_q)
		else $error("record lost on its way to the result register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> res_valid_q && $stable(res_q))
		else $error("held record overwritten or dropped");

endmodule
